// ===== sv/rbss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbss_pkg
// Types and constants shared by the rotor bank substitution stepper.
// ----------------------------------------------------------------------------
package rbss_pkg;

  // symbol code width
  localparam int SYM_W = 21;

  // input field widths
  localparam int OP_W  = 2;
  localparam int RIDX_W = 2;
  localparam int POS_W = 6;

  // configuration register widths and reset values
  localparam int LEN_W     = 7;
  localparam int RCNT_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 7'd26;
  localparam logic [RCNT_W-1:0] RCNT_RESET = 3'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTORS    = 2'd1;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_WIRE  = 2'd0,
    OP_LOAD_ALPHA = 2'd1,
    OP_STEP       = 2'd2,
    OP_SUBST      = 2'd3
  } op_e;

endpackage
`default_nettype wire

// ===== sv/rotor_bank_substitution_stepper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Loads pass from accept through S_DONE to out_valid_o; one word at a time is in work.
// Step: per rotor visited, an offset memory read, then write back; then S_DONE.
// Substitute: an offset read, offset mod length over the LOG2(MAX_SYMBOLS) offset bits,
// a table search over up to alphabet_len entries, then S_DONE.
// Reset clears control and the offset valid bits (offsets read as zero) and loads the
// config reset values; the tables need no clearing pass and hold garbage until written.
// ----------------------------------------------------------------------------
// rotor_bank_substitution_stepper
// Rotor bank: wiring and alphabet tables in synchronous RAM, per-rotor offsets
// in a small RAM, odometer stepping and a sequential search for substitution.
// ----------------------------------------------------------------------------
module rotor_bank_substitution_stepper
  import rbss_pkg::*;
#(
  parameter int NUM_ROTORS  = 4,
  parameter int MAX_SYMBOLS = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // input words
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire  [OP_W-1:0]       op_i,
  input  wire  [RIDX_W-1:0]     rotor_index_i,
  input  wire  [POS_W-1:0]      position_i,
  input  wire  [SYM_W-1:0]      symbol_i,
  input  wire                   reverse_i,
  // result words
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic [SYM_W-1:0]      out_symbol_o,
  output logic                  found_o,
  // configuration writes
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [LEN_W-1:0]      cfg_data_i
);

  localparam int RW  = (NUM_ROTORS > 1) ? $clog2(NUM_ROTORS) : 1;
  localparam int NW  = $clog2(NUM_ROTORS + 1);
  localparam int LW  = $clog2(MAX_SYMBOLS);
  localparam int CW  = $clog2(MAX_SYMBOLS + 1);
  localparam int WD  = NUM_ROTORS * MAX_SYMBOLS;
  localparam int WAW = $clog2(WD);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_OFS     = 3'd1;
  localparam logic [2:0] S_MOD     = 3'd2;
  localparam logic [2:0] S_SRCH    = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;
  localparam logic [2:0] S_STEP_RD = 3'd5;
  localparam logic [2:0] S_STEP_WR = 3'd6;

  // config registers
  logic [LEN_W-1:0]  len_q;
  logic [RCNT_W-1:0] rcnt_q;

  // control
  logic [2:0]        state_q, state_d;
  logic [NW-1:0]     r_q, r_d;
  logic              iss_q, iss_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;

  // datapath
  logic [RW-1:0]     rot_q, rot_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic              rev_q, rev_d;
  logic [SYM_W-1:0]  res_q, res_d;
  logic              fnd_q, fnd_d;
  logic [CW-1:0]     q_q, q_d;
  logic [LW-1:0]     j_q, j_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [LW-1:0]     div_q, div_d;
  logic              lastp_q, lastp_d;
  logic [SYM_W-1:0]  out_symbol_q, out_symbol_d;
  logic              found_q, found_d;

  // memories
  logic [SYM_W-1:0]  wire_mem [WD];
  logic [SYM_W-1:0]  alpha_mem [MAX_SYMBOLS];
  logic [LW-1:0]     off_mem [NUM_ROTORS];
  logic [NUM_ROTORS-1:0] off_vld_q;
  logic [SYM_W-1:0]  wire_rd_q, alpha_rd_q;
  logic [LW-1:0]     off_rd_q;
  logic              off_rd_vld_q;

  logic              wire_we, alpha_we, off_we;
  logic [LW-1:0]     off_wdata;
  logic [WAW-1:0]    wire_waddr, wire_raddr;
  logic [LW-1:0]     alpha_raddr;
  logic [RW-1:0]     off_raddr;
  logic [LW-1:0]     off_val;

  logic [CW-1:0]     len_eff;
  logic [NW-1:0]     rot_n;
  logic              accept, rot_ok, pos_ok;
  logic [CW:0]       rem_sh, rem_nx;
  logic [CW-1:0]     step_v;
  logic [CW-1:0]     j_inc;
  logic              match;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == S_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_symbol_q;
  assign found_o      = found_q;

  // effective length and rotor count
  always_comb begin
    if (len_q == '0) begin
      len_eff = CW'(1);
    end else if (int'(len_q) > MAX_SYMBOLS) begin
      len_eff = CW'(MAX_SYMBOLS);
    end else begin
      len_eff = CW'(len_q);
    end
    if (int'(rcnt_q) > NUM_ROTORS) begin
      rot_n = NW'(NUM_ROTORS);
    end else begin
      rot_n = NW'(rcnt_q);
    end
  end

  assign rot_ok = int'(rotor_index_i) < NUM_ROTORS;
  assign pos_ok = int'(position_i) < MAX_SYMBOLS;

  // addresses
  assign wire_waddr  = WAW'(RW'(rotor_index_i)) * WAW'(MAX_SYMBOLS) + WAW'(position_i);
  assign wire_raddr  = WAW'(rot_q) * WAW'(MAX_SYMBOLS) + WAW'(j_q);
  assign alpha_raddr = q_q[LW-1:0];
  assign off_raddr   = (state_q == S_IDLE) ? RW'(rotor_index_i) : r_q[RW-1:0];
  assign off_val     = off_rd_vld_q ? off_rd_q : '0;

  // offset mod length, one dividend bit per cycle
  assign rem_sh = {rem_q, div_q[LW-1]};
  assign rem_nx = (rem_sh >= {1'b0, len_eff}) ? (rem_sh - {1'b0, len_eff}) : rem_sh;

  assign step_v = CW'(off_val) + CW'(1);
  assign j_inc  = CW'(j_q) + CW'(1);
  assign match  = rev_q ? (wire_rd_q == sym_q) : (alpha_rd_q == sym_q);

  // sequencer
  always_comb begin
    state_d      = state_q;
    r_d          = r_q;
    iss_d        = iss_q;
    pend_d       = 1'b0;
    lastp_d      = 1'b0;
    rot_d        = rot_q;
    sym_d        = sym_q;
    rev_d        = rev_q;
    res_d        = res_q;
    fnd_d        = fnd_q;
    q_d          = q_q;
    j_d          = j_q;
    rem_d        = rem_q;
    div_d        = div_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_symbol_d = out_symbol_q;
    found_d      = found_q;
    wire_we      = 1'b0;
    alpha_we     = 1'b0;
    off_we       = 1'b0;
    off_wdata    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          fnd_d = 1'b1;
          unique case (op_e'(op_i))
            OP_LOAD_WIRE: begin
              wire_we = rot_ok && pos_ok;
              state_d = S_DONE;
            end
            OP_LOAD_ALPHA: begin
              alpha_we = pos_ok;
              state_d  = S_DONE;
            end
            OP_STEP: begin
              r_d     = '0;
              state_d = (rot_n == '0) ? S_DONE : S_STEP_RD;
            end
            OP_SUBST: begin
              fnd_d   = 1'b0;
              rot_d   = RW'(rotor_index_i);
              sym_d   = symbol_i;
              rev_d   = reverse_i;
              state_d = rot_ok ? S_OFS : S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_OFS: begin
        div_d   = off_val;
        rem_d   = '0;
        q_d     = '0;
        state_d = S_MOD;
      end
      S_MOD: begin
        rem_d = CW'(rem_nx);
        div_d = div_q << 1;
        if (q_q == CW'(LW - 1)) begin
          j_d     = LW'(rem_nx);
          q_d     = '0;
          iss_d   = 1'b1;
          state_d = S_SRCH;
        end else begin
          q_d = q_q + CW'(1);
        end
      end
      S_SRCH: begin
        // issue next table read pair
        if (iss_q) begin
          pend_d  = 1'b1;
          lastp_d = (q_q == len_eff - CW'(1));
          iss_d   = (q_q != len_eff - CW'(1));
          q_d     = q_q + CW'(1);
          j_d     = (j_inc == len_eff) ? '0 : LW'(j_inc);
        end
        // check the pair read last cycle
        if (pend_q) begin
          if (match) begin
            res_d   = rev_q ? alpha_rd_q : wire_rd_q;
            fnd_d   = 1'b1;
            iss_d   = 1'b0;
            pend_d  = 1'b0;
            state_d = S_DONE;
          end else if (lastp_q) begin
            iss_d   = 1'b0;
            pend_d  = 1'b0;
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_symbol_d = res_q;
          found_d      = fnd_q;
          state_d      = S_IDLE;
        end
      end
      S_STEP_RD: begin
        state_d = S_STEP_WR;
      end
      S_STEP_WR: begin
        off_we = 1'b1;
        if (step_v >= len_eff) begin
          off_wdata = '0;
          if ((r_q + NW'(1)) < rot_n) begin
            r_d     = r_q + NW'(1);
            state_d = S_STEP_RD;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          off_wdata = LW'(step_v);
          state_d   = S_DONE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      r_q         <= '0;
      iss_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      r_q         <= r_d;
      iss_q       <= iss_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rot_q        <= rot_d;
    sym_q        <= sym_d;
    rev_q        <= rev_d;
    res_q        <= res_d;
    fnd_q        <= fnd_d;
    q_q          <= q_d;
    j_q          <= j_d;
    rem_q        <= rem_d;
    div_q        <= div_d;
    lastp_q      <= lastp_d;
    out_symbol_q <= out_symbol_d;
    found_q      <= found_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_RESET;
      rcnt_q <= RCNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ALPHA_LEN: len_q  <= cfg_data_i;
        CFG_ROTORS:    rcnt_q <= cfg_data_i[RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // wiring table RAM
  always_ff @(posedge clk_i) begin
    if (wire_we) begin
      wire_mem[wire_waddr] <= symbol_i;
    end
    wire_rd_q <= wire_mem[wire_raddr];
  end

  // alphabet table RAM
  always_ff @(posedge clk_i) begin
    if (alpha_we) begin
      alpha_mem[LW'(position_i)] <= symbol_i;
    end
    alpha_rd_q <= alpha_mem[alpha_raddr];
  end

  // offset RAM; entries not yet written read as zero
  always_ff @(posedge clk_i) begin
    if (off_we) begin
      off_mem[r_q[RW-1:0]] <= off_wdata;
    end
    off_rd_q <= off_mem[off_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_vld_q    <= '0;
      off_rd_vld_q <= 1'b0;
    end else begin
      if (off_we) begin
        off_vld_q[r_q[RW-1:0]] <= 1'b1;
      end
      off_rd_vld_q <= off_vld_q[off_raddr];
    end
  end

  // checks
  a_srch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> (iss_q || pend_q))
    else $error("search stalled with nothing in flight");

  a_j_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> (CW'(j_q) < len_eff))
    else $error("rotated index past alphabet length");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP_WR) |-> (r_q < rot_n))
    else $error("stepping past active rotor count");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ((op_e'(op_i) == OP_LOAD_WIRE) || (op_e'(op_i) == OP_LOAD_ALPHA)))
      |=> (state_q == S_DONE))
    else $error("load word did not complete in one cycle");

endmodule
`default_nettype wire
